// ===== src/mqls_pkg.sv =====
// Shared types and default sizes for the multi-queue linked store.
package mqls_pkg;

    localparam int NUM_QUEUES_DEF    = 5;
    localparam int NODE_CAPACITY_DEF = 64;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BADQ  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

endpackage

// ===== src/mqls_node_store.sv =====
// Node store: value and next-pointer memories with registered read data.
module mqls_node_store import mqls_pkg::*; #(
    parameter int NODE_CAPACITY = NODE_CAPACITY_DEF,
    parameter int PW            = $clog2(NODE_CAPACITY)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [PW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_value,
    output logic [PW-1:0] o_rd_next,
    input  logic          i_val_we,
    input  logic [PW-1:0] i_val_addr,
    input  logic [31:0]   i_val_data,
    input  logic          i_next_we,
    input  logic [PW-1:0] i_next_addr,
    input  logic [PW-1:0] i_next_data
);

    logic [31:0]   mem_value [NODE_CAPACITY];
    logic [PW-1:0] mem_next  [NODE_CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_val_we) begin
            mem_value[i_val_addr] <= i_val_data;
        end
        if (i_rd_en) begin
            o_rd_value <= mem_value[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_next_we) begin
            mem_next[i_next_addr] <= i_next_data;
        end
        if (i_rd_en) begin
            o_rd_next <= mem_next[i_rd_addr];
        end
    end

endmodule

// ===== src/multi_queue_linked_store_unit.sv =====
// Several FIFO queues sharing one linked node store with a free list.
// A taken request passes the execute state, then its result is strobed from the output registers.
// A new request is taken only in idle; the node memory read must land before pointers update.
// busy is high for the one execute cycle; the next request can be taken while a result shows.
// Reset (synchronous, active low) empties all queues and the free list; node memory is not cleared.
// Results cannot be stalled by the receiver.
module multi_queue_linked_store_unit import mqls_pkg::*; #(
    parameter int NUM_QUEUES    = NUM_QUEUES_DEF,
    parameter int NODE_CAPACITY = NODE_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [2:0]  i_queue_index,
    input  logic [31:0] i_item_value,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_removed_value
);

    localparam int PW  = $clog2(NODE_CAPACITY);
    localparam int CW  = $clog2(NODE_CAPACITY + 1);
    localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    t_state          r_state, n_state;
    logic            r_cmd, n_cmd;
    logic            r_q_ok, n_q_ok;
    logic [QIW-1:0]  r_qidx, n_qidx;
    logic [31:0]     r_item, n_item;
    logic [PW-1:0]   r_head [NUM_QUEUES];
    logic [PW-1:0]   n_head [NUM_QUEUES];
    logic [PW-1:0]   r_tail [NUM_QUEUES];
    logic [PW-1:0]   n_tail [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] r_nonempty, n_nonempty;
    logic [CW-1:0]   r_fresh_cnt, n_fresh_cnt;
    logic [PW-1:0]   r_free_head, n_free_head;
    logic [CW-1:0]   r_free_cnt, n_free_cnt;
    logic            r_valid, n_valid;
    t_status         r_status, n_status;
    logic [31:0]     r_removed, n_removed;

    logic            in_ok;
    logic [QIW-1:0]  in_idx;
    logic            rd_en;
    logic [PW-1:0]   rd_addr;
    logic [31:0]     rd_value;
    logic [PW-1:0]   rd_next;
    logic            val_we;
    logic [PW-1:0]   val_addr;
    logic            next_we;
    logic [PW-1:0]   next_addr;
    logic [PW-1:0]   next_data;
    logic [PW-1:0]   slot;
    logic [PW-1:0]   cur_head;
    logic [PW-1:0]   cur_tail;

    assign in_ok  = ({1'b0, i_queue_index} < 4'(NUM_QUEUES));
    assign in_idx = in_ok ? i_queue_index[QIW-1:0] : '0;

    assign cur_head = r_head[r_qidx];
    assign cur_tail = r_tail[r_qidx];

    mqls_node_store #(
        .NODE_CAPACITY(NODE_CAPACITY),
        .PW           (PW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_value (rd_value),
        .o_rd_next  (rd_next),
        .i_val_we   (val_we),
        .i_val_addr (val_addr),
        .i_val_data (r_item),
        .i_next_we  (next_we),
        .i_next_addr(next_addr),
        .i_next_data(next_data)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_q_ok      = r_q_ok;
        n_qidx      = r_qidx;
        n_item      = r_item;
        n_head      = r_head;
        n_tail      = r_tail;
        n_nonempty  = r_nonempty;
        n_fresh_cnt = r_fresh_cnt;
        n_free_head = r_free_head;
        n_free_cnt  = r_free_cnt;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_removed   = r_removed;
        rd_en       = 1'b0;
        rd_addr     = r_free_head;
        val_we      = 1'b0;
        val_addr    = '0;
        next_we     = 1'b0;
        next_addr   = '0;
        next_data   = '0;
        slot        = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                    n_cmd   = i_cmd;
                    n_q_ok  = in_ok;
                    n_qidx  = in_idx;
                    n_item  = i_item_value;
                    rd_en   = 1'b1;
                    // A dequeue needs the head node; an enqueue may need the free list link.
                    if (t_cmd'(i_cmd) == CMD_DEQ) begin
                        rd_addr = r_head[in_idx];
                    end else begin
                        rd_addr = r_free_head;
                    end
                end
            end
            S_EXEC: begin
                n_state   = S_IDLE;
                n_valid   = 1'b1;
                n_status  = ST_DONE;
                n_removed = '0;
                if (!r_q_ok) begin
                    n_status = ST_BADQ;
                end else if (t_cmd'(r_cmd) == CMD_ENQ) begin
                    if (r_free_cnt != '0) begin
                        slot        = r_free_head;
                        n_free_head = rd_next;
                        n_free_cnt  = r_free_cnt - 1'b1;
                    end else if (r_fresh_cnt < CW'(NODE_CAPACITY)) begin
                        slot        = r_fresh_cnt[PW-1:0];
                        n_fresh_cnt = r_fresh_cnt + 1'b1;
                    end else begin
                        n_status = ST_FULL;
                    end
                    if (n_status == ST_DONE) begin
                        val_we   = 1'b1;
                        val_addr = slot;
                        if (r_nonempty[r_qidx]) begin
                            next_we   = 1'b1;
                            next_addr = cur_tail;
                            next_data = slot;
                        end else begin
                            n_head[r_qidx]     = slot;
                            n_nonempty[r_qidx] = 1'b1;
                        end
                        n_tail[r_qidx] = slot;
                    end
                end else begin
                    if (!r_nonempty[r_qidx]) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_removed = rd_value;
                        if (cur_head == cur_tail) begin
                            n_nonempty[r_qidx] = 1'b0;
                        end else begin
                            n_head[r_qidx] = rd_next;
                        end
                        // The freed node is pushed onto the free list.
                        next_we     = 1'b1;
                        next_addr   = cur_head;
                        next_data   = r_free_head;
                        n_free_head = cur_head;
                        n_free_cnt  = r_free_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= 1'b0;
            r_nonempty  <= '0;
            r_fresh_cnt <= '0;
            r_free_head <= '0;
            r_free_cnt  <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_nonempty  <= n_nonempty;
            r_fresh_cnt <= n_fresh_cnt;
            r_free_head <= n_free_head;
            r_free_cnt  <= n_free_cnt;
            r_head      <= n_head;
            r_tail      <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_q_ok    <= n_q_ok;
        r_qidx    <= n_qidx;
        r_item    <= n_item;
        r_status  <= n_status;
        r_removed <= n_removed;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;

endmodule
